/* hw/rtl/bia_pkg.sv */
// Types and codes shared by the bitmap ID allocator.
// No dependencies.
`timescale 1ns / 1ps

package bia_pkg;

    localparam int ID_W   = 12;
    localparam int TYPE_W = 2;

    localparam logic [TYPE_W-1:0] REQ_MARK  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_TEST  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_ALLOC = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [ID_W-1:0]   id_index;
    } bia_req_t;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            was_used;
        logic            map_full;
    } bia_res_t;

endpackage

/* hw/rtl/bitmap_id_allocator.sv */
// Bitmap ID allocator: used-ID map in one synchronous memory, first-fit allocate.
// Depends on bia_pkg.
//
// channel  dir  handshake            payload
// req      in   req_valid/req_stall  bia_req_t  (req_type, id_index)
// rsp      out  rsp_valid/rsp_stall  bia_res_t  (result_id, was_used, map_full)
//
// Mark and test run from transfer to result register via quotient and word read,
// bit update or test, and output load. Allocate tests words from the scan pointer,
// then forms the ID and loads the output; a scan pointer past all full words means
// each word is skipped at most once over the life of the map. Request code 3 goes
// straight to output load. A reset clearing pass writes every word with req_stall high.
// A held result does not block the next transfer; it stalls only the load of the
// next result into the output register.
`timescale 1ns / 1ps

module bitmap_id_allocator #(
    parameter int WORD_BITS = 64,
    parameter int MAP_WORDS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  bia_pkg::bia_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output bia_pkg::bia_res_t rsp
);
    import bia_pkg::*;

    localparam int AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PW    = $clog2(MAP_WORDS + 1);
    localparam int BW    = $clog2(WORD_BITS);
    localparam int SW    = PW + BW + 1;
    localparam int SHIFT = 24;
    localparam int RECIP = ((1 << SHIFT) + WORD_BITS - 1) / WORD_BITS;
    localparam logic [WORD_BITS-1:0] ONE_W = WORD_BITS'(1);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_QUO   = 3'd2;
    localparam logic [2:0] S_BIT   = 3'd3;
    localparam logic [2:0] S_AREAD = 3'd4;
    localparam logic [2:0] S_AEVAL = 3'd5;
    localparam logic [2:0] S_AID   = 3'd6;
    localparam logic [2:0] S_PUT   = 3'd7;

    logic [WORD_BITS-1:0] used_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] rdata_reg;

    logic [2:0]        state_reg, state_next;
    logic [AW-1:0]     clr_reg, clr_next;
    logic [PW-1:0]     ptr_reg, ptr_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic [TYPE_W-1:0] type_reg, type_next;
    logic [ID_W-1:0]   id_reg, id_next;
    logic [ID_W-1:0]   q_reg, q_next;
    logic              range_reg, range_next;
    logic [BW-1:0]     idx_reg, idx_next;
    bia_res_t          res_reg, res_next;
    bia_res_t          rsp_reg, rsp_next;

    logic                 re, we;
    logic [AW-1:0]        raddr, waddr;
    logic [WORD_BITS-1:0] wdata;

    logic [35:0]          quo_prod;
    logic [ID_W-1:0]      q_comb;
    logic [17:0]          qw_prod;
    logic [17:0]          rem_full;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] low_bit;
    logic [BW-1:0]        low_idx;
    logic [SW-1:0]        alloc_sum;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign quo_prod  = 36'(id_reg) * 36'(RECIP);
    assign q_comb    = quo_prod[SHIFT+ID_W-1:SHIFT];
    assign qw_prod   = 18'(q_reg) * 18'(WORD_BITS);
    assign rem_full  = 18'(id_reg) - qw_prod;
    assign bit_mask  = ONE_W << rem_full[BW-1:0];
    assign free_bits = ~rdata_reg;
    assign low_bit   = free_bits & (~free_bits + ONE_W);
    assign alloc_sum = SW'(ptr_reg) * SW'(WORD_BITS) + SW'(idx_reg);

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (low_bit[i])
            begin
                low_idx = low_idx | BW'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        ptr_next       = ptr_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        type_next      = type_reg;
        id_next        = id_reg;
        q_next         = q_reg;
        range_next     = range_reg;
        idx_next       = idx_reg;
        res_next       = res_reg;
        re             = 1'b0;
        we             = 1'b0;
        raddr          = ptr_reg[AW-1:0];
        waddr          = ptr_reg[AW-1:0];
        wdata          = rdata_reg;

        case (state_reg)
            S_CLR:
            begin
                we    = 1'b1;
                waddr = clr_reg;
                wdata = (clr_reg == '0) ? ONE_W : '0;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAP_WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    type_next = req.req_type;
                    id_next   = req.id_index;
                    case (req.req_type)
                        REQ_MARK, REQ_TEST: state_next = S_QUO;
                        REQ_ALLOC:          state_next = S_AREAD;
                        default:
                        begin
                            res_next   = '{result_id: req.id_index, was_used: 1'b0,
                                           map_full: 1'b0};
                            state_next = S_PUT;
                        end
                    endcase
                end
            end
            S_QUO:
            begin
                re         = 1'b1;
                raddr      = q_comb[AW-1:0];
                q_next     = q_comb;
                range_next = (32'(q_comb) < MAP_WORDS);
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if ((type_reg == REQ_MARK) && range_reg)
                begin
                    we    = 1'b1;
                    waddr = q_reg[AW-1:0];
                    wdata = rdata_reg | bit_mask;
                end
                res_next = '{result_id: id_reg,
                             was_used: (type_reg == REQ_TEST) && range_reg
                                       && ((rdata_reg & bit_mask) != '0),
                             map_full: 1'b0};
                state_next = S_PUT;
            end
            S_AREAD:
            begin
                if (32'(ptr_reg) < MAP_WORDS)
                begin
                    re         = 1'b1;
                    state_next = S_AEVAL;
                end
                else
                begin
                    res_next   = '{result_id: '0, was_used: 1'b0, map_full: 1'b1};
                    state_next = S_PUT;
                end
            end
            S_AEVAL:
            begin
                if (free_bits == '0)
                begin
                    ptr_next   = ptr_reg + PW'(1);
                    state_next = S_AREAD;
                end
                else
                begin
                    we         = 1'b1;
                    wdata      = rdata_reg | low_bit;
                    idx_next   = low_idx;
                    state_next = S_AID;
                end
            end
            S_AID:
            begin
                res_next   = '{result_id: alloc_sum[ID_W-1:0], was_used: 1'b0,
                               map_full: 1'b0};
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next       = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        type_reg  <= type_next;
        id_reg    <= id_next;
        q_reg     <= q_next;
        range_reg <= range_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        rsp_reg   <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            used_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= used_mem[raddr];
        end
    end

    a_rsp_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == S_PUT))
        else $error("result loaded outside output state");

    a_ptr_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (ptr_reg >= $past(ptr_reg)))
        else $error("scan pointer moved backward");

    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> req_stall)
        else $error("request taken during clearing pass");

    a_eval_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_AEVAL) |-> (32'(ptr_reg) < MAP_WORDS))
        else $error("allocate evaluated a word beyond the map");

endmodule
